>>> design/robot_target_follow_fsm_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the target-follow mode controller
// Clocked, reset-qualified property wrappers used by the RTL files.
// ----------------------------------------------------------------------------
`ifndef ROBOT_TARGET_FOLLOW_FSM_UNIT_MACROS_SVH
`define ROBOT_TARGET_FOLLOW_FSM_UNIT_MACROS_SVH

// same-cycle implication
`define RTF_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RTF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/rtf_pkg.sv
// ----------------------------------------------------------------------------
// rtf_pkg
// Types, codes and reset values shared by the target-follow controller.
// ----------------------------------------------------------------------------
package rtf_pkg;

    localparam int DIST_W        = 16;
    localparam int CFG_W         = 16;
    localparam int CFG_IDX_W     = 3;
    localparam int TIME_BITS_DEF = 24;
    localparam int LANES         = 3;

    // lane positions
    localparam int LANE_LEFT   = 0;
    localparam int LANE_MIDDLE = 1;
    localparam int LANE_RIGHT  = 2;

    localparam logic [DIST_W-1:0] CONTACT_CODE = 16'hFFFF;

    // mode codes
    localparam logic [1:0] MODE_ENTRY   = 2'd0;
    localparam logic [1:0] MODE_BACKOFF = 2'd1;
    localparam logic [1:0] MODE_SEARCH  = 2'd2;
    localparam logic [1:0] MODE_FOLLOW  = 2'd3;

    // drive commands
    localparam logic [2:0] DRV_KEEP   = 3'd0;
    localparam logic [2:0] DRV_FWD    = 3'd1;
    localparam logic [2:0] DRV_REV    = 3'd2;
    localparam logic [2:0] DRV_TANK_L = 3'd3;
    localparam logic [2:0] DRV_TANK_R = 3'd4;
    localparam logic [2:0] DRV_ARC_L  = 3'd5;
    localparam logic [2:0] DRV_ARC_R  = 3'd6;
    localparam logic [2:0] DRV_STOP   = 3'd7;

    // LED modes
    localparam logic [1:0] LED_OFF   = 2'd0;
    localparam logic [1:0] LED_ON    = 2'd1;
    localparam logic [1:0] LED_BLINK = 2'd2;

    // edge event codes
    localparam logic [1:0] EDGE_NONE  = 2'd0;
    localparam logic [1:0] EDGE_LEFT  = 2'd1;
    localparam logic [1:0] EDGE_RIGHT = 2'd2;
    localparam logic [1:0] EDGE_OTHER = 2'd3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RING_THRESHOLD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_MS       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BACKOFF_MS     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SEARCH_INIT_MS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SEARCH_INC_MS  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SEARCH_LIM_MS  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_REGAIN_MS      = 3'd6;

    // register reset values
    localparam logic [CFG_W-1:0] RST_RING_THRESHOLD = 16'd600;
    localparam logic [CFG_W-1:0] RST_ENTRY_MS       = 16'd300;
    localparam logic [CFG_W-1:0] RST_BACKOFF_MS     = 16'd300;
    localparam logic [CFG_W-1:0] RST_SEARCH_INIT_MS = 16'd200;
    localparam logic [CFG_W-1:0] RST_SEARCH_INC_MS  = 16'd100;
    localparam logic [CFG_W-1:0] RST_SEARCH_LIM_MS  = 16'd1000;
    localparam logic [CFG_W-1:0] RST_REGAIN_MS      = 16'd200;

    typedef struct packed {
        logic [CFG_W-1:0] ring_threshold;
        logic [CFG_W-1:0] entry_ms;
        logic [CFG_W-1:0] backoff_ms;
        logic [CFG_W-1:0] search_initial_ms;
        logic [CFG_W-1:0] search_increment_ms;
        logic [CFG_W-1:0] search_limit_ms;
        logic [CFG_W-1:0] regain_timeout_ms;
    } cfg_t;

    // per-sensor findings from one lane
    typedef struct packed {
        logic seen;
        logic contact;
    } lane_flags_t;

    typedef struct packed {
        logic [2:0] drive_cmd;
        logic [1:0] mode;
        logic [1:0] red_led;
        logic [1:0] orange_led;
    } res_t;

endpackage

>>> design/rtf_tick_if.sv
// ----------------------------------------------------------------------------
// rtf_tick_if
// Input channel: one tick with three distance readings and an edge event.
// ----------------------------------------------------------------------------
interface rtf_tick_if;
    import rtf_pkg::*;

    logic              valid;
    logic              ready;
    logic [DIST_W-1:0] left_distance;
    logic [DIST_W-1:0] middle_distance;
    logic [DIST_W-1:0] right_distance;
    logic [1:0]        edge_event;

    modport source (
        output valid, left_distance, middle_distance, right_distance, edge_event,
        input  ready
    );

    modport sink (
        input  valid, left_distance, middle_distance, right_distance, edge_event,
        output ready
    );
endinterface

>>> design/rtf_result_if.sv
// ----------------------------------------------------------------------------
// rtf_result_if
// Output channel: drive command, mode and LED modes for one tick.
// ----------------------------------------------------------------------------
interface rtf_result_if;
    logic       valid;
    logic       ready;
    logic [2:0] drive_cmd;
    logic [1:0] mode;
    logic [1:0] red_led;
    logic [1:0] orange_led;

    modport source (
        output valid, drive_cmd, mode, red_led, orange_led,
        input  ready
    );

    modport sink (
        input  valid, drive_cmd, mode, red_led, orange_led,
        output ready
    );
endinterface

>>> design/rtf_cfg_if.sv
// ----------------------------------------------------------------------------
// rtf_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface rtf_cfg_if;
    import rtf_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_W-1:0]     data;

    modport source (
        output valid, index, data,
        input  ready
    );

    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

>>> design/rtf_lane.sv
// ----------------------------------------------------------------------------
// rtf_lane
// One sensor lane: classifies a distance reading against the ring threshold.
// ----------------------------------------------------------------------------
module rtf_lane (
    input  logic [rtf_pkg::DIST_W-1:0] distance,
    input  logic [rtf_pkg::CFG_W-1:0]  threshold,
    output rtf_pkg::lane_flags_t       flags
);
    import rtf_pkg::*;

    // seen at or below threshold, contact on the reserved code
    always_comb
    begin
        flags.seen    = (distance <= threshold);
        flags.contact = (distance == CONTACT_CODE);
    end
endmodule

>>> design/rtf_core.sv
// ----------------------------------------------------------------------------
// rtf_core
// Merging stage: combines lane flags and edge event into the mode update.
// ----------------------------------------------------------------------------
`include "robot_target_follow_fsm_unit_macros.svh"

module rtf_core #(
    parameter int TIME_BITS = rtf_pkg::TIME_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       accept,
    input  rtf_pkg::lane_flags_t       flags [rtf_pkg::LANES],
    input  logic [1:0]                 edge_event,
    input  rtf_pkg::cfg_t              cfg,
    output rtf_pkg::res_t              res
);
    import rtf_pkg::*;

    localparam logic [TIME_BITS-1:0] TimeMax = '1;

    logic [1:0]           mode_reg,       mode_next;
    logic [TIME_BITS-1:0] time_reg,       time_next;
    logic                 sweep_left_reg, sweep_left_next;
    logic [TIME_BITS-1:0] last_flip_reg,  last_flip_next;
    logic [CFG_W-1:0]     sweep_len_reg,  sweep_len_next;
    logic [TIME_BITS-1:0] lost_reg,       lost_next;
    logic                 seen_left_reg,  seen_left_next;
    logic [3:0]           led_reg,        led_next;

    logic                 entered;
    logic                 start_search;
    logic                 search_left;
    logic                 start_follow;
    logic [2:0]           drv;
    logic [TIME_BITS-1:0] flip_elapsed;
    logic [TIME_BITS-1:0] lost_elapsed;
    logic [CFG_W:0]       sweep_sum;
    logic [CFG_W-1:0]     sweep_sat;
    logic                 lo, mo, ro, lc, mc, rc;

    // elapsed times and saturated sweep growth
    always_comb
    begin
        flip_elapsed = time_reg - last_flip_reg;
        lost_elapsed = time_reg - lost_reg;
        sweep_sum    = {1'b0, sweep_len_reg} + {1'b0, cfg.search_increment_ms};
        sweep_sat    = sweep_sum[CFG_W] ? '1 : sweep_sum[CFG_W-1:0];
        lo = !flags[LANE_LEFT].seen;
        mo = !flags[LANE_MIDDLE].seen;
        ro = !flags[LANE_RIGHT].seen;
        lc = flags[LANE_LEFT].contact;
        mc = flags[LANE_MIDDLE].contact;
        rc = flags[LANE_RIGHT].contact;
    end

    // mode update
    always_comb
    begin
        mode_next       = mode_reg;
        sweep_left_next = sweep_left_reg;
        last_flip_next  = last_flip_reg;
        sweep_len_next  = sweep_len_reg;
        lost_next       = lost_reg;
        seen_left_next  = seen_left_reg;
        led_next        = led_reg;
        drv             = DRV_KEEP;
        entered         = 1'b0;
        start_search    = 1'b0;
        search_left     = 1'b0;
        start_follow    = 1'b0;

        if (edge_event != EDGE_NONE)
        begin
            if (edge_event inside {EDGE_LEFT, EDGE_RIGHT})
            begin
                mode_next = MODE_BACKOFF;
                drv       = DRV_REV;
                entered   = 1'b1;
            end
            else
            begin
                // other cause goes straight on to search
                start_search = 1'b1;
            end
        end
        else
        begin
            case (mode_reg)
                MODE_ENTRY:
                begin
                    if (time_reg == '0)
                        drv = DRV_FWD;
                    if (time_reg >= TIME_BITS'(cfg.entry_ms))
                        start_search = 1'b1;
                end
                MODE_BACKOFF:
                begin
                    if (time_reg >= TIME_BITS'(cfg.backoff_ms))
                        start_search = 1'b1;
                end
                MODE_SEARCH:
                begin
                    if (flags[LANE_MIDDLE].seen)
                        start_follow = 1'b1;
                    else if (flip_elapsed >= TIME_BITS'(sweep_len_reg))
                    begin
                        sweep_left_next = !sweep_left_reg;
                        last_flip_next  = time_reg;
                        if (sweep_len_reg == '0)
                            sweep_len_next = cfg.search_initial_ms;
                        else if (!sweep_left_reg && (sweep_len_reg < cfg.search_limit_ms))
                            sweep_len_next = sweep_sat;
                        drv = sweep_left_reg ? DRV_TANK_R : DRV_TANK_L;
                    end
                end
                default:
                begin
                    // follow: steer from range and contact flags
                    if ((lo && ro && !mo) || mc)
                    begin
                        drv       = DRV_FWD;
                        lost_next = '0;
                    end
                    else if ((!lo && ro) || lc)
                    begin
                        drv            = DRV_ARC_L;
                        seen_left_next = 1'b1;
                        lost_next      = '0;
                    end
                    else if ((lo && !ro) || rc)
                    begin
                        drv            = DRV_ARC_R;
                        seen_left_next = 1'b0;
                        lost_next      = '0;
                    end
                    else if (lost_reg == '0)
                    begin
                        lost_next = time_reg;
                        drv       = DRV_STOP;
                    end
                    else if (lost_elapsed > TIME_BITS'(cfg.regain_timeout_ms))
                    begin
                        start_search = 1'b1;
                        search_left  = !seen_left_reg;
                    end
                end
            endcase
        end

        // mode entry actions
        if (start_search)
        begin
            mode_next       = MODE_SEARCH;
            sweep_left_next = search_left;
            last_flip_next  = '0;
            sweep_len_next  = '0;
            led_next        = {LED_BLINK, LED_ON};
            entered         = 1'b1;
        end
        if (start_follow)
        begin
            mode_next = MODE_FOLLOW;
            lost_next = '0;
            led_next  = {LED_ON, LED_BLINK};
            entered   = 1'b1;
        end

        // time in mode, saturating
        if (entered)
            time_next = '0;
        else if (time_reg != TimeMax)
            time_next = time_reg + TIME_BITS'(1);
        else
            time_next = time_reg;
    end

    // result of this tick
    always_comb
    begin
        res.drive_cmd  = drv;
        res.mode       = mode_next;
        res.red_led    = led_next[1:0];
        res.orange_led = led_next[3:2];
    end

    // state registers, advanced on each accepted tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_ENTRY;
            time_reg       <= '0;
            sweep_left_reg <= 1'b0;
            last_flip_reg  <= '0;
            sweep_len_reg  <= '0;
            lost_reg       <= '0;
            seen_left_reg  <= 1'b0;
            led_reg        <= {LED_OFF, LED_OFF};
        end
        else if (accept)
        begin
            mode_reg       <= mode_next;
            time_reg       <= time_next;
            sweep_left_reg <= sweep_left_next;
            last_flip_reg  <= last_flip_next;
            sweep_len_reg  <= sweep_len_next;
            lost_reg       <= lost_next;
            seen_left_reg  <= seen_left_next;
            led_reg        <= led_next;
        end
    end

    // assertions
    `RTF_ASSERT_NEXT(a_edge_backoff, clk, rst_n, accept && (edge_event == EDGE_LEFT || edge_event == EDGE_RIGHT), mode_reg == MODE_BACKOFF && time_reg == '0, "edge event did not restart back-off")
    `RTF_ASSERT_IMPL(a_flip_order, clk, rst_n, mode_reg == MODE_SEARCH, last_flip_reg <= time_reg, "last flip time ahead of time in mode")
    `RTF_ASSERT_IMPL(a_lost_order, clk, rst_n, mode_reg == MODE_FOLLOW, lost_reg <= time_reg, "lost time ahead of time in mode")
    `RTF_ASSERT_IMPL(a_search_leds, clk, rst_n, mode_reg == MODE_SEARCH, led_reg == {LED_BLINK, LED_ON}, "search LEDs wrong")
endmodule

>>> design/robot_target_follow_fsm_unit.sv
// Latency: a result is valid in the cycle after its tick transfer.
// Throughput: one tick per cycle while result.ready is high; mode update is one
// step between state registers, with an output register parting the channels.
// Reset (asynchronous, active low): state and config registers go to defaults,
// mode is entry with time in mode zero and both LEDs off; no result is pending.
// ----------------------------------------------------------------------------
// robot_target_follow_fsm_unit
// Top level: register file, three sensor lanes, mode update and output stage.
// ----------------------------------------------------------------------------
`include "robot_target_follow_fsm_unit_macros.svh"

module robot_target_follow_fsm_unit #(
    parameter int TIME_BITS = rtf_pkg::TIME_BITS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    rtf_tick_if.sink     tick,
    rtf_result_if.source result,
    rtf_cfg_if.sink      cfg
);
    import rtf_pkg::*;

    cfg_t              cfg_reg;
    logic [DIST_W-1:0] lane_dist [LANES];
    lane_flags_t       flags [LANES];
    res_t              res_comb;
    res_t              res_data_reg;
    logic              res_valid_reg, res_valid_next;
    logic              accept;

    // configuration writes, always taken
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ring_threshold      <= RST_RING_THRESHOLD;
            cfg_reg.entry_ms            <= RST_ENTRY_MS;
            cfg_reg.backoff_ms          <= RST_BACKOFF_MS;
            cfg_reg.search_initial_ms   <= RST_SEARCH_INIT_MS;
            cfg_reg.search_increment_ms <= RST_SEARCH_INC_MS;
            cfg_reg.search_limit_ms     <= RST_SEARCH_LIM_MS;
            cfg_reg.regain_timeout_ms   <= RST_REGAIN_MS;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_RING_THRESHOLD: cfg_reg.ring_threshold      <= cfg.data;
                CFG_ENTRY_MS:       cfg_reg.entry_ms            <= cfg.data;
                CFG_BACKOFF_MS:     cfg_reg.backoff_ms          <= cfg.data;
                CFG_SEARCH_INIT_MS: cfg_reg.search_initial_ms   <= cfg.data;
                CFG_SEARCH_INC_MS:  cfg_reg.search_increment_ms <= cfg.data;
                CFG_SEARCH_LIM_MS:  cfg_reg.search_limit_ms     <= cfg.data;
                CFG_REGAIN_MS:      cfg_reg.regain_timeout_ms   <= cfg.data;
                default:            ;
            endcase
        end
    end

    // sensor lanes
    assign lane_dist[LANE_LEFT]   = tick.left_distance;
    assign lane_dist[LANE_MIDDLE] = tick.middle_distance;
    assign lane_dist[LANE_RIGHT]  = tick.right_distance;

    for (genvar g = 0; g < LANES; g++)
    begin : g_lane
        rtf_lane u_lane (
            .distance  (lane_dist[g]),
            .threshold (cfg_reg.ring_threshold),
            .flags     (flags[g])
        );
    end

    // tick transfer whenever the output stage is free or draining
    assign tick.ready = !res_valid_reg || result.ready;
    assign accept     = tick.valid && tick.ready;

    rtf_core #(
        .TIME_BITS (TIME_BITS)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .flags      (flags),
        .edge_event (tick.edge_event),
        .cfg        (cfg_reg),
        .res        (res_comb)
    );

    // output register
    always_comb
    begin
        if (accept)
            res_valid_next = 1'b1;
        else if (result.ready)
            res_valid_next = 1'b0;
        else
            res_valid_next = res_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else
            res_valid_reg <= res_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            res_data_reg <= res_comb;
    end

    assign result.valid      = res_valid_reg;
    assign result.drive_cmd  = res_data_reg.drive_cmd;
    assign result.mode       = res_data_reg.mode;
    assign result.red_led    = res_data_reg.red_led;
    assign result.orange_led = res_data_reg.orange_led;

    // assertions
    `RTF_ASSERT_NEXT(a_result_follows, clk, rst_n, accept, result.valid, "no result after tick transfer")
    `RTF_ASSERT_IMPL(a_ready_when_free, clk, rst_n, !res_valid_reg, tick.ready, "tick stalled with empty output stage")
    `RTF_ASSERT_NEXT(a_cfg_threshold, clk, rst_n, cfg.valid && cfg.index == CFG_RING_THRESHOLD, cfg_reg.ring_threshold == $past(cfg.data), "threshold write lost")
endmodule
